[rtl/cwd_pkg.sv]
// ----------------------------------------------------------------------------
// cwd_pkg: shared types, constants and the CRC function of the word deframer
// Holds the register reset values, the register index codes, the stream
// widths, the configuration and result records and the bytewise CRC-8 update.
// ----------------------------------------------------------------------------
package cwd_pkg;

    // Register reset values.
    localparam logic [7:0] CRC_POLY_RESET  = 8'h31;
    localparam logic [7:0] CRC_INIT_RESET  = 8'hFF;
    localparam logic [3:0] WORDS_RESET     = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_CRC_POLY  = 2'd0;
    localparam logic [1:0] REG_CRC_INIT  = 2'd1;
    localparam logic [1:0] REG_WORDS     = 2'd2;

    // Widths of the channel payloads.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] crc_polynomial;
        logic [7:0] crc_initial_value;
        logic [3:0] words_per_frame;
    } cfg_t;

    // One result word.
    typedef struct packed {
        logic [31:0] word_value;
        logic [3:0]  word_index;
        logic        crc_error;
        logic        last;
    } result_t;

    // MSB-first CRC-8 update over one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/cwd_in_reg.sv]
// ----------------------------------------------------------------------------
// cwd_in_reg: input register stage
// Captures one received byte and its frame start flag and holds it until the
// framing logic takes it.
// ----------------------------------------------------------------------------
module cwd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    output logic       held_valid,
    input  logic       held_take,
    output logic [7:0] held_byte,
    output logic       held_start
);
    import cwd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;

    // The stage takes a new word when it is empty or is emptied this cycle.
    assign in_ready = !valid_reg || held_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            byte_reg  <= in_byte;
            start_reg <= in_start;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_start = start_reg;

endmodule

[rtl/cwd_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// cwd_frame_ctrl: framing state and CRC check
// Tracks the position within each byte triple and within the frame, runs the
// CRC over the two value bytes and builds word and error results.
// ----------------------------------------------------------------------------
module cwd_frame_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cwd_pkg::cfg_t        cfg,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_start,
    output logic                 res_valid,
    output cwd_pkg::result_t     res
);
    import cwd_pkg::*;

    // Byte phase codes within a triple.
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  crc_reg,    crc_next;
    logic [7:0]  high_reg,   high_next;
    logic [7:0]  low_reg,    low_next;
    logic [15:0] upper_reg,  upper_next;
    logic        half_reg,   half_next;
    logic [3:0]  count_reg,  count_next;
    logic        closed_reg, closed_next;

    logic [1:0]  phase_eff;
    logic        half_eff;
    logic [3:0]  count_eff;
    logic        closed_eff;
    logic [3:0]  count_inc;
    logic        is_last;

    // A frame start restarts every counter before the byte is looked at.
    assign phase_eff  = frame_start ? PH_HIGH : phase_reg;
    assign half_eff   = frame_start ? 1'b0    : half_reg;
    assign count_eff  = frame_start ? 4'd0    : count_reg;
    assign closed_eff = frame_start ? 1'b0    : closed_reg;
    assign count_inc  = count_eff + 4'd1;
    assign is_last    = (count_inc == cfg.words_per_frame);

    // Next state and result for one byte.
    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        upper_next  = upper_reg;
        half_next   = half_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (step) begin
            phase_next  = phase_eff;
            half_next   = half_eff;
            count_next  = count_eff;
            closed_next = closed_eff;
            if (!closed_eff) begin
                unique case (phase_eff)
                    PH_HIGH: begin
                        crc_next   = crc8_byte(cfg.crc_initial_value, rx_byte,
                                               cfg.crc_polynomial);
                        high_next  = rx_byte;
                        phase_next = PH_LOW;
                    end
                    PH_LOW: begin
                        crc_next   = crc8_byte(crc_reg, rx_byte, cfg.crc_polynomial);
                        low_next   = rx_byte;
                        phase_next = PH_CRC;
                    end
                    PH_CRC: begin
                        phase_next = PH_HIGH;
                        if (crc_reg != rx_byte) begin
                            // Mismatch: report and abandon the frame.
                            res_valid      = 1'b1;
                            res.word_index = count_eff;
                            res.crc_error  = 1'b1;
                            res.last       = 1'b1;
                            closed_next    = 1'b1;
                            half_next      = 1'b0;
                        end else if (!half_eff) begin
                            upper_next = {high_reg, low_reg};
                            half_next  = 1'b1;
                        end else begin
                            res_valid      = 1'b1;
                            res.word_value = {upper_reg, high_reg, low_reg};
                            res.word_index = count_eff;
                            res.last       = is_last;
                            half_next      = 1'b0;
                            count_next     = count_inc;
                            if (is_last) begin
                                closed_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HIGH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HIGH;
            crc_reg    <= CRC_INIT_RESET;
            high_reg   <= 8'd0;
            low_reg    <= 8'd0;
            upper_reg  <= 16'd0;
            half_reg   <= 1'b0;
            count_reg  <= 4'd0;
            closed_reg <= 1'b1;
        end else begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            upper_reg  <= upper_next;
            half_reg   <= half_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
        end
    end

endmodule

[rtl/crc_checked_word_deframer_core.sv]
// ----------------------------------------------------------------------------
// crc_checked_word_deframer_core: CRC-checked 32-bit word deframer
// Takes reply bytes on the s_ stream and delivers checked words or a CRC
// error on the m_ stream.
// ----------------------------------------------------------------------------
// Usage:
// Each s_ word carries one received byte in s_tdata; s_tuser marks the first
// byte of a frame. Bytes come as triples of a big-endian 16-bit value and its
// CRC-8. Two good triples, upper half first, give one m_ word holding the
// 32-bit value and its index; m_tlast marks the final word of the frame.
// A CRC mismatch gives one word with m_tuser set, a zero value and m_tlast,
// after which bytes are dropped until the next frame start.
// One byte is accepted per cycle while the output register is not stalled. A
// byte is held in the input register and is then checked into the output
// register, from which any result that it gives goes out on the m_ stream.
// The output register stalls the framing step when it is full and m_tready
// is low; s_tready then falls in the same cycle once the input register
// holds a byte. Reset clears both registers, restores the register defaults
// (polynomial 0x31, start value 0xFF, ten words per frame) and waits for a
// frame start. The configuration port writes one register per cycle; the user
// must write only while the block idles, as the block does not enforce it.
// ----------------------------------------------------------------------------
module crc_checked_word_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // Byte input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [cwd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,                        // [0] frame_start
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [cwd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] word_value,
                                                        // [35:32] word_index,
                                                        // [39:36] zero
    output logic        m_tuser,                        // [0] crc_error
    output logic        m_tlast
);
    import cwd_pkg::*;

    cfg_t       cfg_reg;
    logic       held_valid;
    logic       held_take;
    logic [7:0] held_byte;
    logic       held_start;
    logic       res_valid;
    result_t    res;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_polynomial    <= CRC_POLY_RESET;
            cfg_reg.crc_initial_value <= CRC_INIT_RESET;
            cfg_reg.words_per_frame   <= WORDS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CRC_POLY: cfg_reg.crc_polynomial    <= cfg_wdata;
                REG_CRC_INIT: cfg_reg.crc_initial_value <= cfg_wdata;
                REG_WORDS:    cfg_reg.words_per_frame   <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    cwd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata[7:0]),
        .in_start   (s_tuser),
        .held_valid (held_valid),
        .held_take  (held_take),
        .held_byte  (held_byte),
        .held_start (held_start)
    );

    // The held byte is processed when the output register has room.
    assign held_take = held_valid && (!out_valid_reg || m_tready);

    cwd_frame_ctrl u_frame_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .step        (held_take),
        .rx_byte     (held_byte),
        .frame_start (held_start),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (held_take) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (held_take && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.word_index, out_reg.word_value};
    assign m_tuser  = out_reg.crc_error;
    assign m_tlast  = out_reg.last;

endmodule

[bench/deframe_check.sv]
// ----------------------------------------------------------------------------
// deframe_check: prediction and comparison for the word deframer
// Watches the register port and both streams. It keeps its own copy of the
// framing state, predicts the result word that each accepted byte gives, and
// compares every accepted result word field by field with the oldest
// prediction. The failure count and progress counters go to the bench top.
// ----------------------------------------------------------------------------
module deframe_check
    import cwd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [7:0] rx_byte
    input  logic                   s_tuser,    // [0] frame_start
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,    // [31:0] word_value, [35:32] word_index
    input  logic                   m_tuser,    // [0] crc_error
    input  logic                   m_tlast,
    output int                     fail_count,
    output int                     outstanding,
    output int                     words_checked,
    output int                     errors_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Position of a byte within its value triple.
    localparam logic [1:0] AT_HIGH = 2'd0;
    localparam logic [1:0] AT_LOW  = 2'd1;
    localparam logic [1:0] AT_CRC  = 2'd2;

    // Only the first mismatches are printed; the rest are just counted.
    localparam int REPORT_LIMIT = 30;

    cfg_t        live_cfg;
    logic [1:0]  triple_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  high_byte;
    logic [7:0]  low_byte;
    logic [15:0] upper_half;
    logic        want_lower;
    logic [3:0]  word_idx;
    logic        awaiting_start;
    result_t     expected_words[$];

    // MSB-first CRC-8 step: the byte enters at the top, eight shifts follow.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] acc;
        logic       carry;
        acc = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            carry = acc[7];
            acc   = acc << 1;
            if (carry) begin
                acc = acc ^ poly;
            end
        end
        return acc;
    endfunction

    // Advance the framing state by one accepted byte and queue any result.
    task automatic absorb_byte(input logic [7:0] rx, input logic opens);
        result_t    res;
        logic [3:0] next_idx;
        logic       closes;
        if (opens) begin
            triple_pos     = AT_HIGH;
            want_lower     = 1'b0;
            word_idx       = 4'd0;
            awaiting_start = 1'b0;
        end
        if (!awaiting_start) begin
            case (triple_pos)
                AT_HIGH: begin
                    crc_acc    = crc_step(live_cfg.crc_initial_value, rx,
                                          live_cfg.crc_polynomial);
                    high_byte  = rx;
                    triple_pos = AT_LOW;
                end
                AT_LOW: begin
                    crc_acc    = crc_step(crc_acc, rx, live_cfg.crc_polynomial);
                    low_byte   = rx;
                    triple_pos = AT_CRC;
                end
                default: begin
                    triple_pos = AT_HIGH;
                    if (crc_acc != rx) begin
                        // A bad check byte abandons the frame.
                        res.word_value = 32'h0;
                        res.word_index = word_idx;
                        res.crc_error  = 1'b1;
                        res.last       = 1'b1;
                        expected_words.push_back(res);
                        awaiting_start = 1'b1;
                        want_lower     = 1'b0;
                    end else if (!want_lower) begin
                        upper_half = {high_byte, low_byte};
                        want_lower = 1'b1;
                    end else begin
                        // The end test uses the wrapped 4-bit count.
                        next_idx       = word_idx + 4'd1;
                        closes         = (next_idx == live_cfg.words_per_frame);
                        res.word_value = {upper_half, high_byte, low_byte};
                        res.word_index = word_idx;
                        res.crc_error  = 1'b0;
                        res.last       = closes;
                        expected_words.push_back(res);
                        want_lower = 1'b0;
                        word_idx   = next_idx;
                        if (closes) begin
                            awaiting_start = 1'b1;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic flag(input string field, input longint want, input longint got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Register writes, byte acceptance and result comparison on each edge.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            live_cfg.crc_polynomial    = CRC_POLY_RESET;
            live_cfg.crc_initial_value = CRC_INIT_RESET;
            live_cfg.words_per_frame   = WORDS_RESET;
            triple_pos     = AT_HIGH;
            crc_acc        = CRC_INIT_RESET;
            high_byte      = 8'h0;
            low_byte       = 8'h0;
            upper_half     = 16'h0;
            want_lower     = 1'b0;
            word_idx       = 4'd0;
            awaiting_start = 1'b1;
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CRC_POLY: live_cfg.crc_polynomial    = cfg_wdata;
                    REG_CRC_INIT: live_cfg.crc_initial_value = cfg_wdata;
                    REG_WORDS:    live_cfg.words_per_frame   = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata[7:0], s_tuser);
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    flag("unexpected word", 0, {m_tdata, m_tuser, m_tlast});
                end else begin
                    want = expected_words.pop_front();
                    if (want.crc_error) begin
                        errors_checked++;
                    end else begin
                        words_checked++;
                    end
                    if (m_tdata[31:0] !== want.word_value) begin
                        flag("word_value", want.word_value, m_tdata[31:0]);
                    end
                    if (m_tdata[35:32] !== want.word_index) begin
                        flag("word_index", want.word_index, m_tdata[35:32]);
                    end
                    if (m_tdata[39:36] !== 4'h0) begin
                        flag("tdata padding", 0, m_tdata[39:36]);
                    end
                    if (m_tuser !== want.crc_error) begin
                        flag("crc_error", want.crc_error, m_tuser);
                    end
                    if (m_tlast !== want.last) begin
                        flag("last", want.last, m_tlast);
                    end
                end
            end
        end
        outstanding <= expected_words.size();
    end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the CRC-checked word deframer
// Sends reply frames of value triples, with good and spoilt check bytes,
// restarts mid-frame and stray bytes, under several register settings.
// Both streams idle at random. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cwd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int BYTE_TARGET   = 1000;
    localparam int PHASE_BYTES   = 150;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [1:0]             cfg_index = REG_CRC_POLY;
    logic [7:0]             cfg_wdata = 8'h0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;    // [7:0] rx_byte
    logic                   s_tuser   = 1'b0;  // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [31:0] word_value, [35:32] word_index
    logic                   m_tuser;           // [0] crc_error
    logic                   m_tlast;

    int         fail_count;
    int         outstanding;
    int         words_checked;
    int         errors_checked;
    int         idle_cycles    = 0;
    int         rx_stall_left  = 0;
    int         bytes_framed   = 0;
    int         settings_used  = 1;
    bit         calm           = 1'b0;
    logic [7:0] cur_poly       = CRC_POLY_RESET;
    logic [7:0] cur_init       = CRC_INIT_RESET;
    logic [3:0] cur_words      = WORDS_RESET;

    crc_checked_word_deframer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    deframe_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .words_checked  (words_checked),
        .errors_checked (errors_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // The receiver stalls at random.
    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            m_tready      <= 1'b1;
            rx_stall_left <= pick_gap(calm);
        end
    end

    // Watchdog: too long without any word moving ends the run.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Check byte of a 16-bit value under the current settings, bit by bit.
    function automatic logic [7:0] seal_crc(input logic [15:0] value);
        logic [7:0] acc;
        logic       fb;
        acc = cur_init;
        for (int k = 15; k >= 0; k--) begin
            fb  = acc[7] ^ value[k];
            acc = acc << 1;
            if (fb) begin
                acc = acc ^ cur_poly;
            end
        end
        return acc;
    endfunction

    function automatic int frame_words();
        return (cur_words == 4'd0) ? 16 : int'(cur_words);
    endfunction

    function automatic logic [15:0] random_half();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'h0000;
        end
        if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offer one byte, after a random gap, and wait until it is taken.
    task automatic send_byte(input logic [7:0] value, input logic opens);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= opens;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // One value triple; a non-zero spoil mask corrupts the check byte.
    task automatic send_half(input logic [15:0] value, input logic opens,
                             input logic [7:0] spoil);
        send_byte(value[15:8], opens);
        send_byte(value[7:0], 1'b0);
        send_byte(seal_crc(value) ^ spoil, 1'b0);
        bytes_framed += 3;
    endtask

    // Let every expected result out, then give the pipeline time to empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [7:0] poly, input logic [7:0] init,
                              input logic [3:0] words);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_CRC_POLY;
        cfg_wdata <= poly;
        @(posedge aclk);
        cfg_index <= REG_CRC_INIT;
        cfg_wdata <= init;
        @(posedge aclk);
        cfg_index <= REG_WORDS;
        cfg_wdata <= {4'h0, words};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_poly  = poly;
        cur_init  = init;
        cur_words = words;
        settings_used++;
    endtask

    task automatic send_noise(input int count, input bit may_open);
        for (int k = 0; k < count; k++) begin
            send_byte(8'($urandom_range(0, 255)),
                      may_open && ($urandom_range(0, 3) == 0));
        end
    endtask

    // One random frame: whole, broken by a bad check byte, cut short, or noise.
    task automatic run_frame();
        int kind;
        int halves;
        int stop_at;
        int partial;
        kind   = $urandom_range(0, 99);
        calm   = ($urandom_range(0, 4) == 0);
        halves = 2 * frame_words();
        if (kind < 60) begin
            for (int k = 0; k < halves; k++) begin
                send_half(random_half(), k == 0, 8'h00);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_noise($urandom_range(1, 3), 1'b0);
            end
        end else if (kind < 78) begin
            stop_at = $urandom_range(0, halves - 1);
            for (int k = 0; k <= stop_at; k++) begin
                send_half(random_half(), k == 0,
                          (k == stop_at) ? 8'($urandom_range(1, 255)) : 8'h00);
            end
            send_noise($urandom_range(0, 3), 1'b0);
        end else if (kind < 93) begin
            // The next frame start lands mid-word, mid-triple or between words.
            stop_at = $urandom_range(0, halves - 1);
            partial = $urandom_range((stop_at == 0) ? 1 : 0, 2);
            for (int k = 0; k < stop_at; k++) begin
                send_half(random_half(), k == 0, 8'h00);
            end
            for (int k = 0; k < partial; k++) begin
                send_byte(8'($urandom_range(0, 255)), (stop_at == 0) && (k == 0));
                bytes_framed++;
            end
        end else begin
            send_noise($urandom_range(1, 4), 1'b1);
        end
    endtask

    initial begin
        int phase;
        int phase_end;
        int resume;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset settings.
        calm = 1'b1;
        send_byte(8'hA5, 1'b0);              // stray byte before any frame start
        send_byte(8'hBE, 1'b1);              // frame start, then restart mid-triple
        send_half(16'hBEEF, 1'b1, 8'h00);
        send_half(16'hFFFF, 1'b0, 8'h00);    // word 0 complete
        send_half(16'h0000, 1'b0, 8'hFF);    // bad check byte on word 1
        send_byte(8'h00, 1'b0);              // ignored, frame closed
        send_half(16'h0000, 1'b1, 8'h00);
        send_half(16'h8001, 1'b0, 8'h01);    // bad check byte in a lower half
        send_half(16'h1234, 1'b1, 8'h00);
        send_half(16'h5678, 1'b1, 8'h00);    // restart after an upper half
        send_half(16'hABCD, 1'b0, 8'h00);
        calm = 1'b0;

        // Random phases, each under its own register settings.
        phase = 0;
        while (bytes_framed < BYTE_TARGET) begin
            case (phase)
                0: ;
                1: write_regs(8'h00, 8'h00, 4'd1);
                2: write_regs(8'hFF, 8'hFF, 4'd15);
                3: write_regs(8'h07, 8'h00, 4'd0);
                default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
                                                                : 4'($urandom_range(1, 4)));
            endcase
            // A frame left open may carry on under the new settings.
            if (phase > 0 && $urandom_range(0, 1) == 1) begin
                resume = $urandom_range(1, 4);
                for (int k = 0; k < resume; k++) begin
                    send_half(random_half(), 1'b0, 8'h00);
                end
            end
            phase_end = bytes_framed + PHASE_BYTES;
            while (bytes_framed < phase_end && bytes_framed < BYTE_TARGET) begin
                run_frame();
            end
            phase++;
        end

        drain();
        $display("Covered %0d framed bytes under %0d register settings, extremes included.",
                 bytes_framed, settings_used);
        $display("Compared %0d words and %0d CRC error reports.",
                 words_checked, errors_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[crc_checked_word_deframer_core.f]
rtl/cwd_pkg.sv
rtl/cwd_in_reg.sv
rtl/cwd_frame_ctrl.sv
rtl/crc_checked_word_deframer_core.sv
bench/deframe_check.sv
bench/testbench.sv
